/* hw/rtl/lse_pkg.sv */
// ----------------------------------------------------------------------------
// lse_pkg
// Shared types and constants for the LIFO stack engine: opcodes, error
// codes, the cell shift command and the controller state encoding.
// ----------------------------------------------------------------------------
package lse_pkg;

  localparam int DEPTH_DEF       = 64;
  localparam int ENTRY_WIDTH_DEF = 16;

  localparam int OPCODE_W = 3;
  localparam int ERROR_W  = 2;

  localparam logic [OPCODE_W-1:0] OP_PUSH     = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_POP      = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_PEEK     = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_CLEAR    = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_TRAVERSE = 3'd4;

  localparam logic [ERROR_W-1:0] ERR_NONE  = 2'd0;
  localparam logic [ERROR_W-1:0] ERR_FULL  = 2'd1;
  localparam logic [ERROR_W-1:0] ERR_EMPTY = 2'd2;

  // Move applied to every cell of the chain in the same cycle.
  typedef enum logic [1:0] {
    SH_HOLD,
    SH_PUSH,
    SH_POP,
    SH_ROTATE
  } shift_op_t;

  typedef struct packed {
    shift_op_t op;
    logic      en;
  } shift_ctl_t;

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } lse_state_t;

endpackage

/* hw/rtl/lse_cell.sv */
// ----------------------------------------------------------------------------
// lse_cell
// One stack slot. Takes the neighbor above on push, the neighbor below on
// pop, and on rotate the neighbor below or, at the tail, the top slot.
// ----------------------------------------------------------------------------
module lse_cell
  import lse_pkg::*;
#(
  parameter int ENTRY_WIDTH = ENTRY_WIDTH_DEF
) (
  input  logic                   clk,
  input  shift_ctl_t             ctl,
  input  logic                   is_tail,
  input  logic [ENTRY_WIDTH-1:0] from_above,
  input  logic [ENTRY_WIDTH-1:0] from_below,
  input  logic [ENTRY_WIDTH-1:0] wrap_value,
  output logic [ENTRY_WIDTH-1:0] value
);

  logic [ENTRY_WIDTH-1:0] value_next;

  always_comb begin
    case (ctl.op)
      SH_PUSH:   value_next = from_above;
      SH_POP:    value_next = from_below;
      SH_ROTATE: value_next = is_tail ? wrap_value : from_below;
      default:   value_next = value;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      value <= value_next;
    end
  end

endmodule

/* hw/rtl/lse_ctrl.sv */
// ----------------------------------------------------------------------------
// lse_ctrl
// Controller: fill count, traverse walk counter, cell chain commands and
// the registered result stage.
// ----------------------------------------------------------------------------
module lse_ctrl
  import lse_pkg::*;
#(
  parameter int DEPTH       = DEPTH_DEF,
  parameter int ENTRY_WIDTH = ENTRY_WIDTH_DEF,
  parameter int CNT_W       = $clog2(DEPTH + 1)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   req_valid,
  output logic                   req_stall,
  input  logic [OPCODE_W-1:0]    opcode,
  input  logic [ENTRY_WIDTH-1:0] top_entry,
  output shift_ctl_t             shift_ctl,
  output logic [CNT_W-1:0]       count,
  output logic                   rsp_valid,
  input  logic                   rsp_stall,
  output logic [ENTRY_WIDTH-1:0] entry_value,
  output logic                   has_entry,
  output logic [CNT_W-1:0]       fill_count,
  output logic                   is_empty,
  output logic                   is_full,
  output logic [ERROR_W-1:0]     error_code,
  output logic                   last_result
);

  lse_state_t             state, state_next;
  logic [CNT_W-1:0]       walk, walk_next;
  logic [CNT_W-1:0]       count_next;
  logic                   slot_free, accept, cnt_zero, cnt_full, load;
  logic [ENTRY_WIDTH-1:0] value_next;
  logic                   has_next, last_next;
  logic [ERROR_W-1:0]     err_next;

  assign slot_free = !rsp_valid || !rsp_stall;
  assign req_stall = (state != ST_IDLE) || !slot_free;
  assign accept    = req_valid && !req_stall;
  assign cnt_zero  = (count == '0);
  assign cnt_full  = (count == CNT_W'(DEPTH));

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && opcode == OP_TRAVERSE && !cnt_zero) begin
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        if (slot_free && walk == CNT_W'(1)) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    shift_ctl  = '{op: SH_HOLD, en: 1'b0};
    load       = 1'b0;
    count_next = count;
    walk_next  = walk;
    value_next = '0;
    has_next   = 1'b0;
    last_next  = 1'b1;
    err_next   = ERR_NONE;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          load = 1'b1;
          case (opcode)
            OP_PUSH: begin
              if (cnt_full) begin
                err_next = ERR_FULL;
              end else begin
                shift_ctl  = '{op: SH_PUSH, en: 1'b1};
                count_next = count + CNT_W'(1);
              end
            end
            OP_POP: begin
              if (cnt_zero) begin
                err_next = ERR_EMPTY;
              end else begin
                shift_ctl  = '{op: SH_POP, en: 1'b1};
                count_next = count - CNT_W'(1);
                value_next = top_entry;
                has_next   = 1'b1;
              end
            end
            OP_PEEK: begin
              if (cnt_zero) begin
                err_next = ERR_EMPTY;
              end else begin
                value_next = top_entry;
                has_next   = 1'b1;
              end
            end
            OP_CLEAR: count_next = '0;
            OP_TRAVERSE: begin
              // an empty stack answers at once; otherwise start the walk
              if (!cnt_zero) begin
                load      = 1'b0;
                walk_next = count;
              end
            end
            default: ;
          endcase
        end
      end
      ST_WALK: begin
        if (slot_free) begin
          load       = 1'b1;
          shift_ctl  = '{op: SH_ROTATE, en: 1'b1};
          walk_next  = walk - CNT_W'(1);
          value_next = top_entry;
          has_next   = 1'b1;
          last_next  = (walk == CNT_W'(1));
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      walk      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      walk      <= walk_next;
      rsp_valid <= load || (rsp_valid && rsp_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      entry_value <= value_next;
      has_entry   <= has_next;
      fill_count  <= count_next;
      is_empty    <= (count_next == '0);
      is_full     <= (count_next == CNT_W'(DEPTH));
      error_code  <= err_next;
      last_result <= last_next;
    end
  end

endmodule

/* hw/rtl/lifo_stack_engine_top.sv */
// An accepted transaction's result is registered in the result stage; a traverse
// of a non-empty store first loads the walk counter, then gives its results.
// Push, pop, peek, clear, unused opcodes and traverse on an empty store go at
// one transaction per cycle while results drain; result stalls hold the flow.
// Traverse holds the input until its walk is done, one rotation per result.
// Reset clears count, walk and control, not cells.
// ----------------------------------------------------------------------------
// lifo_stack_engine_top
// Bounded LIFO store built as a chain of DEPTH cells with the top entry in
// cell zero. Push shifts the chain down, pop shifts it up, traverse rotates
// the held entries up through the top cell once.
// ----------------------------------------------------------------------------
module lifo_stack_engine_top
  import lse_pkg::*;
#(
  parameter int DEPTH       = DEPTH_DEF,
  parameter int ENTRY_WIDTH = ENTRY_WIDTH_DEF,
  parameter int CNT_W       = $clog2(DEPTH + 1)
) (
  input  logic                   clk,
  input  logic                   rst,
  // request transaction
  input  logic                   req_valid,
  output logic                   req_stall,
  input  logic [OPCODE_W-1:0]    opcode,
  input  logic [ENTRY_WIDTH-1:0] push_value,
  // result transaction
  output logic                   rsp_valid,
  input  logic                   rsp_stall,
  output logic [ENTRY_WIDTH-1:0] entry_value,
  output logic                   has_entry,
  output logic [CNT_W-1:0]       fill_count,
  output logic                   is_empty,
  output logic                   is_full,
  output logic [ERROR_W-1:0]     error_code,
  output logic                   last_result
);

  // cell values, index 0 is the top of the stack
  logic [ENTRY_WIDTH-1:0] cells [DEPTH];
  logic [DEPTH-1:0]       tail;
  logic [CNT_W-1:0]       count;
  shift_ctl_t             shift_ctl;

  // Controller: sequences each transaction, owns the count and result stage.
  lse_ctrl #(
    .DEPTH       (DEPTH),
    .ENTRY_WIDTH (ENTRY_WIDTH),
    .CNT_W       (CNT_W)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .opcode      (opcode),
    .top_entry   (cells[0]),
    .shift_ctl   (shift_ctl),
    .count       (count),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .entry_value (entry_value),
    .has_entry   (has_entry),
    .fill_count  (fill_count),
    .is_empty    (is_empty),
    .is_full     (is_full),
    .error_code  (error_code),
    .last_result (last_result)
  );

  // Cell chain. On rotate, the cell at the current fill depth takes the old
  // top value, so after count steps the held entries are back in place.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [ENTRY_WIDTH-1:0] above, below;

    assign tail[i] = (count == CNT_W'(i + 1));

    if (i == 0) begin : g_first
      assign above = push_value;
    end else begin : g_mid_above
      assign above = cells[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign below = '0;
    end else begin : g_mid_below
      assign below = cells[i+1];
    end

    lse_cell #(
      .ENTRY_WIDTH (ENTRY_WIDTH)
    ) u_cell (
      .clk        (clk),
      .ctl        (shift_ctl),
      .is_tail    (tail[i]),
      .from_above (above),
      .from_below (below),
      .wrap_value (cells[0]),
      .value      (cells[i])
    );
  end

endmodule

/* verif/tb_lifo_stack_engine_top.sv */
// ----------------------------------------------------------------------------
// tb_lifo_stack_engine_top
// Self-checking bench for the LIFO stack engine. A queue of request
// transactions (directed corners, then random fill, drain and mixed runs)
// feeds a clocked driver. A stack predictor builds the expected results at
// each accepted request, and a clocked monitor compares them field by field.
// Both channels see random idle and stall gaps.
// ----------------------------------------------------------------------------
module tb_lifo_stack_engine_top;
  import lse_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH       = DEPTH_DEF;
  localparam int ENTRY_WIDTH = ENTRY_WIDTH_DEF;
  localparam int CNT_W       = $clog2(DEPTH + 1);

  // Opcodes that the block has no operation for; it must answer with status.
  localparam logic [OPCODE_W-1:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [OPCODE_W-1:0] OP_SPARE_LAST  = 3'd7;

  localparam int unsigned REQ_TARGET   = 230;
  localparam int unsigned SETTLE_LEN   = 16;
  localparam int unsigned CYCLE_LIMIT  = 2_500_000;
  localparam int unsigned PRINT_LIMIT  = 100;

  typedef struct {
    logic [OPCODE_W-1:0]    op;
    logic [ENTRY_WIDTH-1:0] value;
    bit                     settle;  // hold until every result is back
  } stack_req_t;

  typedef struct {
    logic [ENTRY_WIDTH-1:0] value;
    logic                   has;
    logic [CNT_W-1:0]       fill;
    logic                   empty;
    logic                   full;
    logic [ERROR_W-1:0]     err;
    logic                   last;
  } stack_result_t;

  // --------------------------------------------------------------------------
  // Clock, reset and DUT
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst = 1'b1;

  always #5 clk = ~clk;

  logic                   req_valid  = 1'b0;
  logic                   req_stall;
  logic [OPCODE_W-1:0]    opcode     = OP_PUSH;
  logic [ENTRY_WIDTH-1:0] push_value = '0;
  logic                   rsp_valid;
  logic                   rsp_stall  = 1'b0;
  logic [ENTRY_WIDTH-1:0] entry_value;
  logic                   has_entry;
  logic [CNT_W-1:0]       fill_count;
  logic                   is_empty;
  logic                   is_full;
  logic [ERROR_W-1:0]     error_code;
  logic                   last_result;

  lifo_stack_engine_top #(
    .DEPTH       (DEPTH),
    .ENTRY_WIDTH (ENTRY_WIDTH)
  ) DUT (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .opcode      (opcode),
    .push_value  (push_value),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .entry_value (entry_value),
    .has_entry   (has_entry),
    .fill_count  (fill_count),
    .is_empty    (is_empty),
    .is_full     (is_full),
    .error_code  (error_code),
    .last_result (last_result)
  );

  // --------------------------------------------------------------------------
  // Stack predictor: its own copy of the store and the fill count
  // --------------------------------------------------------------------------
  logic [ENTRY_WIDTH-1:0] model_mem [DEPTH];
  int unsigned            stack_fill;

  stack_req_t    pending_reqs[$];
  stack_result_t expected_results[$];

  // run statistics for the summary
  int unsigned op_counts [8];
  int unsigned deepest_fill, full_rejects, empty_errors, longest_walk;
  int unsigned results_seen, error_count, cycle_count;

  // Queue one result that reports the fill state after the operation.
  function automatic void queue_result(logic [ENTRY_WIDTH-1:0] value, logic has,
                                       logic [ERROR_W-1:0] err, logic last);
    stack_result_t r;
    r.value = has ? value : '0;
    r.has   = has;
    r.fill  = stack_fill[CNT_W-1:0];
    r.empty = (stack_fill == 0);
    r.full  = (stack_fill == DEPTH);
    r.err   = err;
    r.last  = last;
    expected_results.push_back(r);
  endfunction

  function automatic void predict_results(stack_req_t item);
    int unsigned k;
    op_counts[item.op]++;
    case (item.op)
      OP_PUSH: begin
        if (stack_fill == DEPTH) begin
          full_rejects++;
          queue_result('0, 1'b0, ERR_FULL, 1'b1);
        end else begin
          model_mem[stack_fill] = item.value;
          stack_fill++;
          queue_result('0, 1'b0, ERR_NONE, 1'b1);
        end
      end
      OP_POP, OP_PEEK: begin
        if (stack_fill == 0) begin
          empty_errors++;
          queue_result('0, 1'b0, ERR_EMPTY, 1'b1);
        end else begin
          // pop takes the top off first, so the count it reports is one less
          if (item.op == OP_POP) stack_fill--;
          queue_result(model_mem[(item.op == OP_POP) ? stack_fill : stack_fill - 1],
                       1'b1, ERR_NONE, 1'b1);
        end
      end
      OP_CLEAR: begin
        stack_fill = 0;
        queue_result('0, 1'b0, ERR_NONE, 1'b1);
      end
      OP_TRAVERSE: begin
        if (stack_fill == 0) begin
          queue_result('0, 1'b0, ERR_NONE, 1'b1);
        end else begin
          // walk from the top entry down to the bottom one
          for (k = stack_fill; k > 0; k--) begin
            queue_result(model_mem[k - 1], 1'b1, ERR_NONE, k == 1);
          end
          if (stack_fill > longest_walk) longest_walk = stack_fill;
        end
      end
      default: begin
        queue_result('0, 1'b0, ERR_NONE, 1'b1);
      end
    endcase
    if (stack_fill > deepest_fill) deepest_fill = stack_fill;
  endfunction

  // --------------------------------------------------------------------------
  // Mismatch reporting
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string what);
    // keep the log bounded on a badly broken design; still count everything
    if (error_count < PRINT_LIMIT) $display("[%0t] MISMATCH: %s", $realtime, what);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d %s = 0x%0h, expected 0x%0h",
                                results_seen, name, got, want));
    end
  endtask

  // --------------------------------------------------------------------------
  // Idle gaps: mostly none or short, a few long, with quiet stretches
  // --------------------------------------------------------------------------
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // --------------------------------------------------------------------------
  // Driver: present the head of the pending queue; advance on acceptance
  // --------------------------------------------------------------------------
  int unsigned req_gap, req_quiet;

  always @(posedge clk) begin : drive_requests
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!(req_valid && req_stall)) begin
      // the current transaction, if any, was taken at this edge
      if (req_valid) begin
        predict_results(pending_reqs.pop_front());
        if (req_quiet > 0) begin
          req_quiet--;
          req_gap = 0;
        end else begin
          req_gap = pick_gap();
          if ($urandom_range(19) == 0) req_quiet = $urandom_range(40, 15);
        end
      end
      if (req_gap > 0) begin
        req_gap--;
        req_valid <= 1'b0;
      end else if (pending_reqs.size() != 0 &&
                   !(pending_reqs[0].settle && expected_results.size() != 0)) begin
        req_valid  <= 1'b1;
        opcode     <= pending_reqs[0].op;
        push_value <= pending_reqs[0].value;
      end else begin
        // nothing left, or hold off until the outstanding results drain
        req_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: take results, compare with the oldest expectation, stall at random
  // --------------------------------------------------------------------------
  int unsigned stall_left, stall_quiet;

  always @(posedge clk) begin : watch_results
    stack_result_t want;
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result %0d, entry_value 0x%0h",
                                    results_seen, entry_value));
        end else begin
          want = expected_results.pop_front();
          check_field("entry_value", 32'(entry_value), 32'(want.value));
          check_field("has_entry",   32'(has_entry),   32'(want.has));
          check_field("fill_count",  32'(fill_count),  32'(want.fill));
          check_field("is_empty",    32'(is_empty),    32'(want.empty));
          check_field("is_full",     32'(is_full),     32'(want.full));
          check_field("error_code",  32'(error_code),  32'(want.err));
          check_field("last_result", 32'(last_result), 32'(want.last));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= 1'b0;
        if (stall_quiet > 0) begin
          stall_quiet--;
        end else begin
          stall_left = pick_gap();
          if ($urandom_range(29) == 0) stall_quiet = $urandom_range(60, 20);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected",
               cycle_count, expected_results.size());
      $display("tb_lifo_stack_engine_top: errors");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  function automatic void add_req(logic [OPCODE_W-1:0] op,
                                  logic [ENTRY_WIDTH-1:0] value, bit settle);
    stack_req_t r;
    r.op     = op;
    r.value  = value;
    r.settle = settle;
    pending_reqs.push_back(r);
  endfunction

  function automatic logic [ENTRY_WIDTH-1:0] rand_value();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return ENTRY_WIDTH'($urandom());
    endcase
  endfunction

  // Operation mix per run kind: fill leans on push, drain on pop.
  function automatic logic [OPCODE_W-1:0] pick_op(int unsigned kind);
    int unsigned roll;
    roll = $urandom_range(99);
    case (kind)
      0: begin
        if (roll < 85) return OP_PUSH;
        if (roll < 92) return OP_PEEK;
        if (roll < 97) return OP_POP;
        return OP_TRAVERSE;
      end
      1: begin
        if (roll < 80) return OP_POP;
        if (roll < 90) return OP_PEEK;
        if (roll < 97) return OP_PUSH;
        return OP_TRAVERSE;
      end
      default: begin
        if (roll < 35) return OP_PUSH;
        if (roll < 60) return OP_POP;
        if (roll < 75) return OP_PEEK;
        if (roll < 83) return OP_TRAVERSE;
        if (roll < 88) return OP_CLEAR;
        return OPCODE_W'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST));
      end
    endcase
  endfunction

  initial begin : run_test
    int unsigned kind, run_len, i;

    // directed corners: empty-store errors and walk, both value extremes,
    // pop to empty, spare opcodes, clear on a non-empty and an empty store
    add_req(OP_TRAVERSE, 16'h5A5A, 1'b0);
    add_req(OP_POP,      16'hFFFF, 1'b0);
    add_req(OP_PEEK,     16'h0000, 1'b0);
    add_req(OP_PUSH,     16'h0000, 1'b0);
    add_req(OP_PUSH,     16'hFFFF, 1'b0);
    add_req(OP_PEEK,     16'h1111, 1'b0);
    add_req(OP_TRAVERSE, 16'h2222, 1'b0);
    add_req(OP_PUSH,     16'hA5A5, 1'b0);
    add_req(OP_POP,      16'h3333, 1'b0);
    add_req(OP_POP,      16'h4444, 1'b0);
    add_req(OP_POP,      16'h5555, 1'b0);
    add_req(OP_POP,      16'h6666, 1'b0);
    add_req(OP_PUSH,     16'h1234, 1'b0);
    for (i = OP_SPARE_FIRST; i <= OP_SPARE_LAST; i++) add_req(OPCODE_W'(i), 16'hFFFF, 1'b0);
    add_req(OP_CLEAR,    16'hFFFF, 1'b0);
    add_req(OP_TRAVERSE, 16'h0000, 1'b0);
    add_req(OP_CLEAR,    16'h0000, 1'b0);
    add_req(OP_PUSH,     16'h8001, 1'b0);
    add_req(OP_PUSH,     16'h7FFE, 1'b0);
    add_req(OP_TRAVERSE, 16'h0000, 1'b1);

    // fill past the top to hit the full flag and the rejected push,
    // then walk a full store
    add_req(OP_PUSH, rand_value(), 1'b1);
    for (i = 0; i < DEPTH + 2; i++) add_req(OP_PUSH, rand_value(), 1'b0);
    add_req(OP_PEEK, rand_value(), 1'b0);
    add_req(OP_TRAVERSE, rand_value(), 1'b0);

    // random fill, drain and mixed runs with random content
    while (pending_reqs.size() < REQ_TARGET) begin
      kind    = $urandom_range(2);
      run_len = $urandom_range(30, 8);
      for (i = 0; i < run_len; i++) begin
        add_req(pick_op(kind), rand_value(), $urandom_range(39) == 0);
      end
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // wait for every transaction to go out, then for every result to return
    while (pending_reqs.size() != 0 || req_valid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_LEN) @(posedge clk);

    if (expected_results.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
    end

    $display("covered push %0d, pop %0d, peek %0d, clear %0d, traverse %0d, spare %0d;",
             op_counts[OP_PUSH], op_counts[OP_POP], op_counts[OP_PEEK],
             op_counts[OP_CLEAR], op_counts[OP_TRAVERSE],
             op_counts[5] + op_counts[6] + op_counts[7]);
    $display("%0d results checked, deepest fill %0d, full rejects %0d, %s %0d, %s %0d",
             results_seen, deepest_fill, full_rejects, "empty errors", empty_errors,
             "longest walk", longest_walk);

    if (error_count == 0) begin
      $display("tb_lifo_stack_engine_top: clean");
    end else begin
      $display("%0d mismatches", error_count);
      $display("tb_lifo_stack_engine_top: errors");
    end
    $finish;
  end

endmodule
